>>> design/tcr_pkg.sv
// ----------------------------------------------------------------------------
// tcr_pkg
// Shared widths, register indexes and orientation codes for the touch
// calibration and rotation pipeline.
// ----------------------------------------------------------------------------
package tcr_pkg;

  localparam int CAL_BITS      = 14;
  localparam int DIM_BITS      = 12;
  localparam int POS_BITS      = 14;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = (CAL_BITS > DIM_BITS) ? CAL_BITS : DIM_BITS;

  // quotient bits resolved per divider stage
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = (DIM_BITS + DIV_STEP - 1) / DIV_STEP;
  // input stage, multiply stage, divider stages, output stage
  localparam int NUM_STAGES = DIV_STAGES + 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SENSOR_ENABLE  = 3'd0,
    REG_CAL_X_LEFT     = 3'd1,
    REG_CAL_X_RIGHT    = 3'd2,
    REG_CAL_Y_TOP      = 3'd3,
    REG_CAL_Y_BOTTOM   = 3'd4,
    REG_DISPLAY_WIDTH  = 3'd5,
    REG_DISPLAY_HEIGHT = 3'd6,
    REG_ORIENTATION    = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ORIENT_PORTRAIT       = 2'd0,
    ORIENT_LANDSCAPE      = 2'd1,
    ORIENT_PORTRAIT_FLIP  = 2'd2,
    ORIENT_LANDSCAPE_FLIP = 2'd3
  } orient_e;

  typedef struct packed {
    logic                res_ok;
    logic                raw;
    logic [CAL_BITS-1:0] raw_x;
    logic [CAL_BITS-1:0] raw_y;
  } ctl_t;

  // one axis in flight: remainder, divisor and a shift word that holds the
  // remaining low dividend bits and collects quotient bits
  typedef struct packed {
    logic                sat;
    logic [CAL_BITS-1:0] rem;
    logic [CAL_BITS-1:0] dvs;
    logic [DIM_BITS-1:0] nq;
  } axis_t;

endpackage

>>> design/touch_calibrate_rotate.sv
// ----------------------------------------------------------------------------
// touch_calibrate_rotate
// Two-point touch calibration: per-axis linear scaling by pipelined
// restoring division, clamping and four-way display rotation.
// ----------------------------------------------------------------------------
// Accepts one touch sample per clock while the output is not stalled and
// returns one result per sample, in order. The pipeline has one input
// stage, one multiply stage, six divider stages of two quotient bits each and
// one output register; the divider depth follows from the 12-bit display
// span. Each stage holds while the one after it is full and stalled, so
// bubbles are squeezed out. Configuration is written through the cfg channel,
// which is always ready, and must only change while the pipeline is empty.
module touch_calibrate_rotate (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcr_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [tcr_pkg::CFG_DATA_BITS-1:0] cfg_data_i,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tcr_pkg::CAL_BITS-1:0]  sample_x_i,
  input  logic [tcr_pkg::CAL_BITS-1:0]  sample_y_i,
  input  logic                          touched_i,
  input  logic                          raw_mode_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          valid_res_o,
  output logic [tcr_pkg::POS_BITS-1:0]  pos_x_o,
  output logic [tcr_pkg::POS_BITS-1:0]  pos_y_o
);

  import tcr_pkg::*;

  localparam int NUM_BITS = CAL_BITS + DIM_BITS;
  localparam int LAST     = NUM_STAGES - 1;

  // configuration registers
  logic                sensor_enable_q;
  logic [CAL_BITS-1:0] cal_x_left_q;
  logic [CAL_BITS-1:0] cal_x_right_q;
  logic [CAL_BITS-1:0] cal_y_top_q;
  logic [CAL_BITS-1:0] cal_y_bottom_q;
  logic [DIM_BITS-1:0] display_width_q;
  logic [DIM_BITS-1:0] display_height_q;
  logic [1:0]          orientation_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_enable_q  <= 1'b0;
      cal_x_left_q     <= '0;
      cal_x_right_q    <= '0;
      cal_y_top_q      <= '0;
      cal_y_bottom_q   <= '0;
      display_width_q  <= DIM_BITS'(240);
      display_height_q <= DIM_BITS'(320);
      orientation_q    <= ORIENT_PORTRAIT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SENSOR_ENABLE:  sensor_enable_q  <= cfg_data_i[0];
        REG_CAL_X_LEFT:     cal_x_left_q     <= cfg_data_i[CAL_BITS-1:0];
        REG_CAL_X_RIGHT:    cal_x_right_q    <= cfg_data_i[CAL_BITS-1:0];
        REG_CAL_Y_TOP:      cal_y_top_q      <= cfg_data_i[CAL_BITS-1:0];
        REG_CAL_Y_BOTTOM:   cal_y_bottom_q   <= cfg_data_i[CAL_BITS-1:0];
        REG_DISPLAY_WIDTH:  display_width_q  <= cfg_data_i[DIM_BITS-1:0];
        REG_DISPLAY_HEIGHT: display_height_q <= cfg_data_i[DIM_BITS-1:0];
        REG_ORIENTATION:    orientation_q    <= cfg_data_i[1:0];
      endcase
    end
  end

  // spans
  logic [DIM_BITS-1:0] wspan;
  logic [DIM_BITS-1:0] hspan;
  logic                span_ok;

  assign wspan   = (display_width_q > display_height_q) ? display_width_q : display_height_q;
  assign hspan   = (display_width_q > display_height_q) ? display_height_q : display_width_q;
  assign span_ok = (display_width_q != '0) && (display_height_q != '0);

  function automatic axis_t div_step(axis_t a);
    logic [CAL_BITS:0] t;
    axis_t             r;
    r = a;
    t = {a.rem, a.nq[DIM_BITS-1]};
    if (t >= {1'b0, a.dvs}) begin
      r.rem = CAL_BITS'(t - {1'b0, a.dvs});
      r.nq  = {a.nq[DIM_BITS-2:0], 1'b1};
    end else begin
      r.rem = t[CAL_BITS-1:0];
      r.nq  = {a.nq[DIM_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic axis_t front_axis(logic [CAL_BITS-1:0] s, logic [CAL_BITS-1:0] lo,
                                       logic [CAL_BITS-1:0] hi);
    axis_t r;
    r.sat = (s >= hi);
    r.rem = (s <= lo) ? '0 : s - lo;
    r.dvs = hi - lo;
    r.nq  = '0;
    return r;
  endfunction

  // pipeline
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] v_d;
  logic [NUM_STAGES-1:0] en;
  ctl_t                  ctl_q [LAST];
  ctl_t                  ctl_d [LAST];
  axis_t                 ax_q  [LAST][2];
  axis_t                 ax_d  [LAST][2];

  logic                  out_res_q;
  logic                  out_raw_q;
  logic [POS_BITS-1:0]   out_x_q;
  logic [POS_BITS-1:0]   out_y_q;
  logic [POS_BITS-1:0]   out_x_d;
  logic [POS_BITS-1:0]   out_y_d;

  always_comb begin
    en[LAST] = !v_q[LAST] || out_ready_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = in_valid_i;
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_d[k] = v_q[k-1];
    end
  end

  assign in_ready_o = en[0];

  logic [NUM_BITS-1:0] prod [2];
  logic [DIM_BITS-1:0] span [2];

  assign span[0] = wspan;
  assign span[1] = hspan;

  always_comb begin
    axis_t tmp;
    // input stage
    ctl_d[0].raw    = raw_mode_i;
    ctl_d[0].raw_x  = sample_x_i;
    ctl_d[0].raw_y  = sample_y_i;
    ctl_d[0].res_ok = sensor_enable_q && touched_i &&
                      (raw_mode_i || ((cal_x_right_q > cal_x_left_q) &&
                                      (cal_y_bottom_q > cal_y_top_q) && span_ok));
    ax_d[0][0] = front_axis(sample_x_i, cal_x_left_q, cal_x_right_q);
    ax_d[0][1] = front_axis(sample_y_i, cal_y_top_q, cal_y_bottom_q);
    for (int k = 1; k < LAST; k++) begin
      ctl_d[k] = ctl_q[k-1];
    end
    // multiply stage
    for (int a = 0; a < 2; a++) begin
      prod[a]        = NUM_BITS'(ax_q[0][a].rem) * NUM_BITS'(span[a]);
      ax_d[1][a]     = ax_q[0][a];
      ax_d[1][a].rem = prod[a][NUM_BITS-1:DIM_BITS];
      ax_d[1][a].nq  = prod[a][DIM_BITS-1:0];
    end
    // divider stages
    for (int j = 0; j < DIV_STAGES; j++) begin
      for (int a = 0; a < 2; a++) begin
        tmp = ax_q[j+1][a];
        for (int s = 0; s < DIV_STEP; s++) begin
          if (j * DIV_STEP + s < DIM_BITS) begin
            tmp = div_step(tmp);
          end
        end
        ax_d[j+2][a] = tmp;
      end
    end
  end

  // output stage: clamp, rotate, select
  logic [DIM_BITS-1:0] sx;
  logic [DIM_BITS-1:0] sy;
  logic [DIM_BITS-1:0] px;
  logic [DIM_BITS-1:0] py;

  assign sx = ax_q[LAST-1][0].sat ? wspan - 1'b1 : ax_q[LAST-1][0].nq;
  assign sy = ax_q[LAST-1][1].sat ? hspan - 1'b1 : ax_q[LAST-1][1].nq;

  always_comb begin
    unique case (orient_e'(orientation_q))
      ORIENT_PORTRAIT: begin
        px = sy;
        py = wspan - 1'b1 - sx;
      end
      ORIENT_LANDSCAPE: begin
        px = wspan - 1'b1 - sx;
        py = hspan - 1'b1 - sy;
      end
      ORIENT_PORTRAIT_FLIP: begin
        px = hspan - 1'b1 - sy;
        py = sx;
      end
      ORIENT_LANDSCAPE_FLIP: begin
        px = sx;
        py = sy;
      end
    endcase
    if (!ctl_q[LAST-1].res_ok) begin
      out_x_d = '0;
      out_y_d = '0;
    end else if (ctl_q[LAST-1].raw) begin
      out_x_d = POS_BITS'(ctl_q[LAST-1].raw_x);
      out_y_d = POS_BITS'(ctl_q[LAST-1].raw_y);
    end else begin
      out_x_d = POS_BITS'(px);
      out_y_d = POS_BITS'(py);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LAST; k++) begin
      if (en[k]) begin
        ctl_q[k]   <= ctl_d[k];
        ax_q[k][0] <= ax_d[k][0];
        ax_q[k][1] <= ax_d[k][1];
      end
    end
    if (en[LAST]) begin
      out_res_q <= ctl_q[LAST-1].res_ok;
      out_raw_q <= ctl_q[LAST-1].raw;
      out_x_q   <= out_x_d;
      out_y_q   <= out_y_d;
    end
  end

  assign out_valid_o = v_q[LAST];
  assign valid_res_o = out_res_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;

`ifndef ASSERT_OFF
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output register is empty");

  a_invalid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (pos_x_o == '0 && pos_y_o == '0))
    else $error("invalid result carries a nonzero position");

  a_pos_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && valid_res_o && !out_raw_q) |->
      (pos_x_o < POS_BITS'(wspan) && pos_y_o < POS_BITS'(wspan)))
    else $error("calibrated position outside display span");
`endif

endmodule

>>> dv/tb_touch_calibrate_rotate.sv
// ----------------------------------------------------------------------------
// tb_touch_calibrate_rotate
// Self-checking bench for the touch calibration and rotation pipeline.
// ----------------------------------------------------------------------------
// A driver feeds touch samples from a pending queue and a monitor drains the
// results, both with random gaps. Every accepted sample is run through a local
// calibration predictor and the result it should give is queued; each result
// is checked field by field against the oldest queued one. The run walks
// through reset values, directed corner samples in all four orientations,
// degenerate and disabled calibrations, extreme spans, and random phases, one
// of which holds the output off long enough to back the pipeline up.
// ----------------------------------------------------------------------------
module tb_touch_calibrate_rotate;

  import tcr_pkg::*;

  localparam int          PHASES         = 12;
  localparam int          PHASE_SAMPLES  = 70;
  localparam int          HOLD_CYCLES    = 80;
  localparam int          END_PAUSE      = 60;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          MAX_REPORTS    = 100;
  localparam logic [CAL_BITS-1:0] SAMPLE_MAX = {CAL_BITS{1'b1}};

  typedef struct packed {
    logic [CAL_BITS-1:0] sample_x;
    logic [CAL_BITS-1:0] sample_y;
    logic                touched;
    logic                raw_mode;
  } touch_t;

  typedef struct packed {
    logic                valid_res;
    logic [POS_BITS-1:0] pos_x;
    logic [POS_BITS-1:0] pos_y;
  } position_t;

  typedef struct packed {
    logic                en;
    logic [CAL_BITS-1:0] x_left;
    logic [CAL_BITS-1:0] x_right;
    logic [CAL_BITS-1:0] y_top;
    logic [CAL_BITS-1:0] y_bottom;
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    orient_e             orient;
  } cal_set_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i  = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic [CAL_BITS-1:0]      sample_x_i  = '0;
  logic [CAL_BITS-1:0]      sample_y_i  = '0;
  logic                     touched_i   = 1'b0;
  logic                     raw_mode_i  = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic                     valid_res_o;
  logic [POS_BITS-1:0]      pos_x_o;
  logic [POS_BITS-1:0]      pos_y_o;

  touch_t      touch_pending[$];
  position_t   pos_expected[$];
  touch_t      next_touch;
  position_t   pos_want;
  cal_set_t    cal_regs;
  cal_set_t    plan;
  orient_e     orient_order[4] = '{ORIENT_PORTRAIT, ORIENT_LANDSCAPE,
                                   ORIENT_PORTRAIT_FLIP, ORIENT_LANDSCAPE_FLIP};
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;
  logic        sender_idle_en   = 1'b1;
  logic        receiver_idle_en = 1'b1;
  logic        hold_asked       = 1'b0;
  logic        hold_given;

  touch_calibrate_rotate i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_x_i  (sample_x_i),
    .sample_y_i  (sample_y_i),
    .touched_i   (touched_i),
    .raw_mode_i  (raw_mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .valid_res_o (valid_res_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // calibration predictor
  // ---------------------------------------------------------------------------
  function automatic logic [POS_BITS-1:0] scale_to_span(
    input logic [CAL_BITS-1:0] s, input logic [CAL_BITS-1:0] lo,
    input logic [CAL_BITS-1:0] hi, input logic [DIM_BITS-1:0] span);
    logic [31:0] q;
    if (s <= lo) return '0;
    q = (32'(s - lo) * 32'(span)) / 32'(hi - lo);
    if (q >= 32'(span)) q = 32'(span) - 32'd1;
    return POS_BITS'(q);
  endfunction

  function automatic position_t predict_position(input touch_t t, input cal_set_t c);
    position_t           p;
    logic [DIM_BITS-1:0] wspan;
    logic [DIM_BITS-1:0] hspan;
    logic [POS_BITS-1:0] sx;
    logic [POS_BITS-1:0] sy;
    logic [POS_BITS-1:0] w_last;
    logic [POS_BITS-1:0] h_last;
    p = '0;
    if (!c.en || !t.touched) return p;
    if (t.raw_mode) begin
      p.valid_res = 1'b1;
      p.pos_x     = t.sample_x;
      p.pos_y     = t.sample_y;
      return p;
    end
    if (c.x_right <= c.x_left || c.y_bottom <= c.y_top) return p;
    if (c.width > c.height) begin
      wspan = c.width;
      hspan = c.height;
    end else begin
      wspan = c.height;
      hspan = c.width;
    end
    if (wspan == '0 || hspan == '0) return p;
    sx     = scale_to_span(t.sample_x, c.x_left, c.x_right, wspan);
    sy     = scale_to_span(t.sample_y, c.y_top, c.y_bottom, hspan);
    w_last = POS_BITS'(wspan) - 1'b1;
    h_last = POS_BITS'(hspan) - 1'b1;
    p.valid_res = 1'b1;
    case (c.orient)
      ORIENT_PORTRAIT: begin
        p.pos_x = sy;
        p.pos_y = w_last - sx;
      end
      ORIENT_LANDSCAPE: begin
        p.pos_x = w_last - sx;
        p.pos_y = h_last - sy;
      end
      ORIENT_PORTRAIT_FLIP: begin
        p.pos_x = h_last - sy;
        p.pos_y = sx;
      end
      default: begin
        p.pos_x = sx;
        p.pos_y = sy;
      end
    endcase
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // mostly around the calibrated window, some edges and some anywhere
  function automatic logic [CAL_BITS-1:0] random_sample(
    input logic [CAL_BITS-1:0] lo, input logic [CAL_BITS-1:0] hi);
    int unsigned r;
    int          a;
    int          b;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return SAMPLE_MAX;
        2:       return lo;
        default: return hi;
      endcase
    end
    if (r < 30 || hi <= lo) return CAL_BITS'($urandom_range(0, int'(SAMPLE_MAX)));
    a = int'(lo) - 64;
    b = int'(hi) + 64;
    if (a < 0) a = 0;
    if (b > int'(SAMPLE_MAX)) b = int'(SAMPLE_MAX);
    return CAL_BITS'($urandom_range(a, b));
  endfunction

  function automatic cal_set_t random_settings(input int phase);
    cal_set_t s;
    s.en       = 1'b1;
    s.x_left   = CAL_BITS'($urandom_range(0, 9000));
    s.x_right  = CAL_BITS'($urandom_range(int'(s.x_left) + 1, int'(SAMPLE_MAX)));
    s.y_top    = CAL_BITS'($urandom_range(0, 9000));
    s.y_bottom = CAL_BITS'($urandom_range(int'(s.y_top) + 1, int'(SAMPLE_MAX)));
    if ($urandom_range(0, 1)) begin
      s.width  = DIM_BITS'($urandom_range(1, 400));
      s.height = DIM_BITS'($urandom_range(1, 400));
    end else begin
      s.width  = DIM_BITS'($urandom_range(1, 4095));
      s.height = DIM_BITS'($urandom_range(1, 4095));
    end
    s.orient = orient_order[phase % 4];
    case (phase)
      0: begin
        s.x_left   = '0;
        s.x_right  = SAMPLE_MAX;
        s.y_top    = '0;
        s.y_bottom = SAMPLE_MAX;
        s.width    = {DIM_BITS{1'b1}};
        s.height   = {DIM_BITS{1'b1}};
      end
      1: begin
        s.x_left   = SAMPLE_MAX - 1'b1;
        s.x_right  = SAMPLE_MAX;
        s.y_top    = '0;
        s.y_bottom = CAL_BITS'(1);
        s.width    = DIM_BITS'(1);
        s.height   = DIM_BITS'(1);
      end
      2: begin
        s.width  = {DIM_BITS{1'b1}};
        s.height = DIM_BITS'(1);
      end
      3: begin
        s.width  = DIM_BITS'(1);
        s.height = {DIM_BITS{1'b1}};
      end
      4: s.x_right  = CAL_BITS'($urandom_range(0, int'(s.x_left)));
      5: s.en       = 1'b0;
      6: s.y_bottom = CAL_BITS'($urandom_range(0, int'(s.y_top)));
      default: ;
    endcase
    return s;
  endfunction

  task automatic queue_touch(input logic [CAL_BITS-1:0] x, input logic [CAL_BITS-1:0] y,
                             input logic touched, input logic raw_mode);
    touch_pending.push_back({x, y, touched, raw_mode});
  endtask

  // writes every register, starting at a rising edge
  task automatic apply_settings(input cal_set_t s);
    logic [CFG_DATA_BITS-1:0] word;
    cfg_reg_e                 idx;
    idx = idx.first();
    do begin
      case (idx)
        REG_SENSOR_ENABLE:  word = CFG_DATA_BITS'(s.en);
        REG_CAL_X_LEFT:     word = CFG_DATA_BITS'(s.x_left);
        REG_CAL_X_RIGHT:    word = CFG_DATA_BITS'(s.x_right);
        REG_CAL_Y_TOP:      word = CFG_DATA_BITS'(s.y_top);
        REG_CAL_Y_BOTTOM:   word = CFG_DATA_BITS'(s.y_bottom);
        REG_DISPLAY_WIDTH:  word = CFG_DATA_BITS'(s.width);
        REG_DISPLAY_HEIGHT: word = CFG_DATA_BITS'(s.height);
        default:            word = CFG_DATA_BITS'(s.orient);
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= word;
      do @(posedge clk_i); while (!cfg_ready_o);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_valid_i <= 1'b0;
    cal_regs = s;
  endtask

  // returns at a rising edge once every queued sample has come back
  task automatic wait_settled();
    do @(negedge clk_i);
    while (touch_pending.size() != 0 || in_valid_i || pos_expected.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // sample driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pos_expected.push_back(predict_position(
          {sample_x_i, sample_y_i, touched_i, raw_mode_i}, cal_regs));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (touch_pending.size() != 0) begin
          next_touch  = touch_pending.pop_front();
          in_valid_i <= 1'b1;
          sample_x_i <= next_touch.sample_x;
          sample_y_i <= next_touch.sample_y;
          touched_i  <= next_touch.touched;
          raw_mode_i <= next_touch.raw_mode;
          send_gap   <= (sender_idle_en && $urandom_range(0, 99) < 40) ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // position monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  <= 0;
      hold_given  <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pos_expected.size() == 0) begin
          report_mismatch($sformatf("position %0d,%0d valid %0b with no request outstanding",
                                    pos_x_o, pos_y_o, valid_res_o));
        end else begin
          pos_want = pos_expected.pop_front();
          if (valid_res_o !== pos_want.valid_res)
            report_mismatch($sformatf("valid_res got %0b want %0b",
                                      valid_res_o, pos_want.valid_res));
          if (pos_x_o !== pos_want.pos_x)
            report_mismatch($sformatf("pos_x got %0d want %0d", pos_x_o, pos_want.pos_x));
          if (pos_y_o !== pos_want.pos_y)
            report_mismatch($sformatf("pos_y got %0d want %0d", pos_y_o, pos_want.pos_y));
        end
      end
      if (recv_stall != 0) begin
        recv_stall  <= recv_stall - 1;
        out_ready_i <= 1'b0;
      end else if (hold_asked && !hold_given && out_valid_o) begin
        // long hold-off so the pipeline backs up into the input
        recv_stall  <= HOLD_CYCLES;
        hold_given  <= 1'b1;
        out_ready_i <= 1'b0;
      end else if (receiver_idle_en && $urandom_range(0, 99) < 25) begin
        recv_stall  <= pick_gap() - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    cal_regs = '{en: 1'b0, x_left: '0, x_right: '0, y_top: '0, y_bottom: '0,
                 width: DIM_BITS'(240), height: DIM_BITS'(320), orient: ORIENT_PORTRAIT};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: sensor disabled
    queue_touch(CAL_BITS'(8000), CAL_BITS'(8000), 1'b1, 1'b0);
    queue_touch(SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b1);
    wait_settled();

    plan = '{en: 1'b1, x_left: CAL_BITS'(1000), x_right: CAL_BITS'(15000),
             y_top: CAL_BITS'(2000), y_bottom: CAL_BITS'(14000),
             width: DIM_BITS'(240), height: DIM_BITS'(320), orient: ORIENT_PORTRAIT};
    foreach (orient_order[o]) begin
      plan.orient = orient_order[o];
      apply_settings(plan);
      if (orient_order[o] == ORIENT_PORTRAIT) begin
        queue_touch('0, '0, 1'b1, 1'b0);
        queue_touch(SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b0);
        queue_touch(plan.x_left, plan.y_top, 1'b1, 1'b0);
        queue_touch(plan.x_right, plan.y_bottom, 1'b1, 1'b0);
        queue_touch(plan.x_left + 1'b1, plan.y_top + 1'b1, 1'b1, 1'b0);
        queue_touch(CAL_BITS'(8000), CAL_BITS'(8000), 1'b0, 1'b0);
        queue_touch(SAMPLE_MAX, '0, 1'b1, 1'b1);
        queue_touch('0, SAMPLE_MAX, 1'b1, 1'b1);
        queue_touch(CAL_BITS'(5000), CAL_BITS'(6000), 1'b0, 1'b1);
        queue_touch(CAL_BITS'(8000), CAL_BITS'(8000), 1'b1, 1'b0);
      end else begin
        queue_touch('0, SAMPLE_MAX, 1'b1, 1'b0);
        queue_touch(SAMPLE_MAX, '0, 1'b1, 1'b0);
        queue_touch(CAL_BITS'(9000), CAL_BITS'(7000), 1'b1, 1'b0);
      end
      wait_settled();
    end

    // degenerate calibration, raw mode still passes through
    plan.x_right = plan.x_left;
    apply_settings(plan);
    queue_touch(CAL_BITS'(8000), CAL_BITS'(8000), 1'b1, 1'b0);
    queue_touch(CAL_BITS'(8000), CAL_BITS'(8000), 1'b1, 1'b1);
    queue_touch(CAL_BITS'(8000), CAL_BITS'(8000), 1'b0, 1'b0);
    wait_settled();

    // sensor disabled overrides raw mode
    plan.x_right = CAL_BITS'(15000);
    plan.en      = 1'b0;
    apply_settings(plan);
    queue_touch(CAL_BITS'(8000), CAL_BITS'(8000), 1'b1, 1'b1);
    queue_touch(CAL_BITS'(8000), CAL_BITS'(8000), 1'b1, 1'b0);
    wait_settled();

    for (int p = 0; p < PHASES; p++) begin
      plan = random_settings(p);
      apply_settings(plan);
      sender_idle_en   <= (p % 3 != 2);
      receiver_idle_en <= (p % 3 != 2);
      if (p == 8) hold_asked <= 1'b1;
      repeat (PHASE_SAMPLES) begin
        queue_touch(random_sample(plan.x_left, plan.x_right),
                    random_sample(plan.y_top, plan.y_bottom),
                    $urandom_range(0, 99) >= 8, $urandom_range(0, 99) < 15);
      end
      wait_settled();
    end

    repeat (END_PAUSE) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
design/tcr_pkg.sv
design/touch_calibrate_rotate.sv
dv/tb_touch_calibrate_rotate.sv
